/* hdl/prv0_pkg.sv */
// Shared types and codes for the produce response (v0) parser.
// No dependencies; used by every module of the block.
package prv0_pkg;

  localparam logic [1:0] KIND_TOPIC = 2'd0;
  localparam logic [1:0] KIND_PART  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_BADTOPIC = 3'd3;
  localparam logic [2:0] ST_BADNAME  = 3'd4;
  localparam logic [2:0] ST_BADPART  = 3'd5;

  localparam int HEADER_BYTES = 12;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  status;
    logic [31:0] correlation_id;
    logic [30:0] topic_number;
    logic [14:0] name_length;
    logic [30:0] partition_total;
    logic [30:0] partition_position;
    logic [31:0] partition_id;
    logic [15:0] partition_error;
    logic [63:0] partition_offset;
  } res_t;

endpackage

/* hdl/prv0_parse.sv */
// Byte-wide parse engine: field assembly, phase tracking and result build.
// Depends on prv0_pkg.
module prv0_parse (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [7:0]     data_byte,
  input  logic           start_flag,
  input  logic           final_flag,
  output logic           res_v,
  output prv0_pkg::res_t res
);
  import prv0_pkg::*;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_SIZE   = 4'd1;
  localparam logic [3:0] PH_CORR   = 4'd2;
  localparam logic [3:0] PH_TCOUNT = 4'd3;
  localparam logic [3:0] PH_NLEN   = 4'd4;
  localparam logic [3:0] PH_NAME   = 4'd5;
  localparam logic [3:0] PH_PCOUNT = 4'd6;
  localparam logic [3:0] PH_PID    = 4'd7;
  localparam logic [3:0] PH_PERR   = 4'd8;
  localparam logic [3:0] PH_POFF   = 4'd9;
  localparam logic [3:0] PH_TRAIL  = 4'd10;

  localparam logic [32:0] POS_MAX = '1;

  logic [3:0]  phase, phase_next;
  logic [3:0]  field_bytes, field_bytes_next;
  logic [63:0] field_shift, field_shift_next;
  logic [32:0] message_length, message_length_next;
  logic [32:0] byte_position, byte_position_next;
  logic [31:0] held_correlation, held_correlation_next;
  logic [30:0] topics_total, topics_total_next;
  logic [30:0] topic_counter, topic_counter_next;
  logic [14:0] name_remaining, name_remaining_next;
  logic [30:0] partitions_total, partitions_total_next;
  logic [30:0] partition_counter, partition_counter_next;
  logic [31:0] held_partition_id, held_partition_id_next;
  logic [14:0] held_name_len, held_name_len_next;
  logic [15:0] held_err_code, held_err_code_next;
  logic        pend_valid, pend_valid_next;
  logic [1:0]  pend_kind, pend_kind_next;
  logic [2:0]  pend_status, pend_status_next;
  logic [31:0] pend_corr, pend_corr_next;

  always_comb begin
    logic [3:0]  phase_w;
    logic [32:0] idx;
    logic [33:0] cnt;
    logic [3:0]  need;
    logic [3:0]  fb;
    logic [63:0] fs;
    logic [31:0] v32;
    logic [15:0] nl16;
    logic [14:0] nl;
    logic [14:0] nr;
    logic [30:0] tc;
    logic [30:0] pc;
    logic [2:0]  err;
    logic        have_rec;
    res_t        rec;
    logic        have_term;
    logic [1:0]  tk;
    logic [2:0]  ts;

    phase_next             = phase;
    field_bytes_next       = field_bytes;
    field_shift_next       = field_shift;
    message_length_next    = message_length;
    byte_position_next     = byte_position;
    held_correlation_next  = held_correlation;
    topics_total_next      = topics_total;
    topic_counter_next     = topic_counter;
    name_remaining_next    = name_remaining;
    partitions_total_next  = partitions_total;
    partition_counter_next = partition_counter;
    held_partition_id_next = held_partition_id;
    held_name_len_next     = held_name_len;
    held_err_code_next     = held_err_code;
    pend_valid_next        = pend_valid;
    pend_kind_next         = pend_kind;
    pend_status_next       = pend_status;
    pend_corr_next         = pend_corr;

    phase_w   = phase;
    idx       = '0;
    cnt       = '0;
    need      = 4'd4;
    fb        = '0;
    fs        = '0;
    v32       = '0;
    nl16      = '0;
    nl        = '0;
    nr        = '0;
    tc        = '0;
    pc        = '0;
    err       = ST_OK;
    have_rec  = 1'b0;
    rec       = '0;
    have_term = 1'b0;
    tk        = KIND_ERROR;
    ts        = ST_OK;
    res_v     = 1'b0;
    res       = '0;

    if (go) begin
      if (pend_valid) begin
        pend_valid_next = 1'b0;
      end
      if (start_flag) begin
        phase_w                = PH_SIZE;
        phase_next             = PH_SIZE;
        field_bytes_next       = '0;
        field_shift_next       = '0;
        message_length_next    = '0;
        byte_position_next     = '0;
        held_correlation_next  = '0;
        topics_total_next      = '0;
        topic_counter_next     = '0;
        name_remaining_next    = '0;
        partitions_total_next  = '0;
        partition_counter_next = '0;
        held_partition_id_next = '0;
        held_name_len_next     = '0;
        held_err_code_next     = '0;
      end

      if (phase_w != PH_IDLE) begin
        idx = byte_position_next;
        byte_position_next = (idx < POS_MAX) ? idx + 33'd1 : POS_MAX;

        if (phase_w >= PH_NLEN && phase_w <= PH_POFF && idx >= message_length_next) begin
          err = ST_TRUNC;
        end else if (phase_w == PH_NAME) begin
          nr = name_remaining_next - 15'd1;
          name_remaining_next = nr;
          if (nr == '0) begin
            phase_next = PH_PCOUNT;
          end
        end else if (phase_w != PH_TRAIL) begin
          case (phase_w) inside
            PH_NLEN, PH_PERR: need = 4'd2;
            PH_POFF:          need = 4'd8;
            default:          need = 4'd4;
          endcase
          fs = {field_shift_next[55:0], data_byte};
          fb = field_bytes_next + 4'd1;
          field_shift_next = fs;
          field_bytes_next = fb;
          if (fb >= need) begin
            v32  = fs[31:0];
            nl16 = fs[15:0];
            unique case (phase_w)
              PH_SIZE: begin
                message_length_next = {1'b0, v32} + 33'd4;
                phase_next = PH_CORR;
              end
              PH_CORR: begin
                held_correlation_next = v32;
                phase_next = PH_TCOUNT;
              end
              PH_TCOUNT: begin
                if (v32[31]) begin
                  err = ST_BADTOPIC;
                end else begin
                  topics_total_next  = v32[30:0];
                  topic_counter_next = '0;
                  phase_next = (v32 != '0) ? PH_NLEN : PH_TRAIL;
                end
              end
              PH_NLEN: begin
                if (nl16 == 16'hFFFF) begin
                  nl = '0;
                end else begin
                  nl = nl16[14:0];
                end
                if (nl16 != 16'hFFFF && nl16[15]) begin
                  err = ST_BADNAME;
                end else begin
                  held_name_len_next  = nl;
                  name_remaining_next = nl;
                  phase_next = (nl != '0) ? PH_NAME : PH_PCOUNT;
                end
              end
              PH_PCOUNT: begin
                if (v32[31]) begin
                  err = ST_BADPART;
                end else begin
                  partitions_total_next  = v32[30:0];
                  partition_counter_next = '0;
                  have_rec = 1'b1;
                  rec.record_kind     = KIND_TOPIC;
                  rec.correlation_id  = held_correlation_next;
                  rec.topic_number    = topic_counter_next;
                  rec.name_length     = held_name_len_next;
                  rec.partition_total = v32[30:0];
                  if (v32 != '0) begin
                    phase_next = PH_PID;
                  end else begin
                    tc = topic_counter_next + 31'd1;
                    topic_counter_next = tc;
                    phase_next = (tc < topics_total_next) ? PH_NLEN : PH_TRAIL;
                  end
                end
              end
              PH_PID: begin
                held_partition_id_next = v32;
                phase_next = PH_PERR;
              end
              PH_PERR: begin
                held_err_code_next = v32[15:0];
                phase_next = PH_POFF;
              end
              PH_POFF: begin
                have_rec = 1'b1;
                rec.record_kind        = KIND_PART;
                rec.correlation_id     = held_correlation_next;
                rec.topic_number       = topic_counter_next;
                rec.name_length        = held_name_len_next;
                rec.partition_total    = partitions_total_next;
                rec.partition_position = partition_counter_next;
                rec.partition_id       = held_partition_id_next;
                rec.partition_error    = held_err_code_next;
                rec.partition_offset   = fs;
                pc = partition_counter_next + 31'd1;
                partition_counter_next = pc;
                if (pc < partitions_total_next) begin
                  phase_next = PH_PID;
                end else begin
                  tc = topic_counter_next + 31'd1;
                  topic_counter_next = tc;
                  phase_next = (tc < topics_total_next) ? PH_NLEN : PH_TRAIL;
                end
              end
              default: ;
            endcase
            field_bytes_next = '0;
            field_shift_next = '0;
          end
        end

        if (final_flag) begin
          cnt = {1'b0, idx} + 34'd1;
          have_term = 1'b1;
          tk = KIND_ERROR;
          if (cnt < 34'(HEADER_BYTES)) begin
            ts = ST_SHORT;
          end else if (cnt < {1'b0, message_length_next}) begin
            ts = ST_TRUNC;
          end else if (err != ST_OK) begin
            ts = err;
          end else if (phase_next == PH_TRAIL) begin
            tk = KIND_DONE;
            ts = ST_OK;
          end else begin
            ts = ST_TRUNC;
          end
          phase_next = PH_IDLE;
        end else if (err != ST_OK) begin
          have_term = 1'b1;
          tk = KIND_ERROR;
          ts = err;
          phase_next = PH_IDLE;
        end
      end

      if (pend_valid) begin
        res_v = 1'b1;
        res.record_kind    = pend_kind;
        res.status         = pend_status;
        res.correlation_id = pend_corr;
      end else if (have_rec) begin
        res_v = 1'b1;
        res   = rec;
      end else if (have_term) begin
        res_v = 1'b1;
        res.record_kind    = tk;
        res.status         = ts;
        res.correlation_id = held_correlation_next;
      end
      if (have_term && (pend_valid || have_rec)) begin
        pend_valid_next  = 1'b1;
        pend_kind_next   = tk;
        pend_status_next = ts;
        pend_corr_next   = held_correlation_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      field_bytes       <= '0;
      field_shift       <= '0;
      message_length    <= '0;
      byte_position     <= '0;
      held_correlation  <= '0;
      topics_total      <= '0;
      topic_counter     <= '0;
      name_remaining    <= '0;
      partitions_total  <= '0;
      partition_counter <= '0;
      held_partition_id <= '0;
      held_name_len     <= '0;
      held_err_code     <= '0;
      pend_valid        <= 1'b0;
      pend_kind         <= '0;
      pend_status       <= '0;
      pend_corr         <= '0;
    end else begin
      phase             <= phase_next;
      field_bytes       <= field_bytes_next;
      field_shift       <= field_shift_next;
      message_length    <= message_length_next;
      byte_position     <= byte_position_next;
      held_correlation  <= held_correlation_next;
      topics_total      <= topics_total_next;
      topic_counter     <= topic_counter_next;
      name_remaining    <= name_remaining_next;
      partitions_total  <= partitions_total_next;
      partition_counter <= partition_counter_next;
      held_partition_id <= held_partition_id_next;
      held_name_len     <= held_name_len_next;
      held_err_code     <= held_err_code_next;
      pend_valid        <= pend_valid_next;
      pend_kind         <= pend_kind_next;
      pend_status       <= pend_status_next;
      pend_corr         <= pend_corr_next;
    end
  end

endmodule

/* hdl/prv0_skid.sv */
// Result register plus one skid entry between the parse engine and the output.
// Depends on prv0_pkg.
module prv0_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_v,
  input  prv0_pkg::res_t in_res,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output prv0_pkg::res_t out_res
);
  import prv0_pkg::*;

  logic r_valid;
  logic s_valid;
  res_t r_data;
  res_t s_data;
  logic take;

  assign take      = r_valid && !out_stall;
  assign full      = s_valid;
  assign out_valid = r_valid;
  assign out_res   = r_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (s_valid) begin
      if (take) begin
        s_valid <= 1'b0;
      end
    end else if (in_v) begin
      if (!r_valid || take) begin
        r_valid <= 1'b1;
      end else begin
        s_valid <= 1'b1;
      end
    end else if (take) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid) begin
      if (take) begin
        r_data <= s_data;
      end
    end else if (in_v) begin
      if (!r_valid || take) begin
        r_data <= in_res;
      end else begin
        s_data <= in_res;
      end
    end
  end

endmodule

/* hdl/produce_response_v0_parser_unit.sv */
// Produce response (v0) parser: one response byte in per transfer, at most one
// record out per byte. Combinational parse engine followed by a result register
// with a single skid entry.
//
// The parser takes one byte per clock while src_stall is low: every byte is
// parsed in the cycle it is transferred and its record (topic, partition, done
// or error) is registered in the result register, or in the skid entry while
// the result register is stalled. The two-entry result buffer lets bytes keep
// flowing while a result waits; src_stall rises only when both entries are full,
// so the sustained rate is set by the result side. When one byte both closes a
// record and ends the message, the terminal result is held inside the parser and
// delivered with the next byte transferred.
module produce_response_v0_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  logic [7:0]         data_byte,
  input  logic               start_flag,
  input  logic               final_flag,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [1:0]         record_kind,
  output logic [2:0]         status,
  output logic signed [31:0] correlation_id,
  output logic [30:0]        topic_number,
  output logic [14:0]        name_length,
  output logic [30:0]        partition_total,
  output logic [30:0]        partition_position,
  output logic signed [31:0] partition_id,
  output logic signed [15:0] partition_error,
  output logic signed [63:0] partition_offset
);
  import prv0_pkg::*;

  logic go;
  logic eng_v;
  res_t eng_res;
  res_t out_res;
  logic full;

  assign go        = src_valid && !full;
  assign src_stall = full;

  prv0_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .data_byte  (data_byte),
    .start_flag (start_flag),
    .final_flag (final_flag),
    .res_v      (eng_v),
    .res        (eng_res)
  );

  prv0_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_v      (eng_v),
    .in_res    (eng_res),
    .full      (full),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_res   (out_res)
  );

  assign record_kind        = out_res.record_kind;
  assign status             = out_res.status;
  assign correlation_id     = $signed(out_res.correlation_id);
  assign topic_number       = out_res.topic_number;
  assign name_length        = out_res.name_length;
  assign partition_total    = out_res.partition_total;
  assign partition_position = out_res.partition_position;
  assign partition_id       = $signed(out_res.partition_id);
  assign partition_error    = $signed(out_res.partition_error);
  assign partition_offset   = $signed(out_res.partition_offset);

endmodule

/* hdl/prv0_check.sv */
// Port-level checks for the produce response parser, with the bind to the top.
// Depends on prv0_pkg and produce_response_v0_parser_unit.
module prv0_check (
  input logic               clk,
  input logic               rst,
  input logic               src_stall,
  input logic               res_valid,
  input logic               res_stall,
  input logic [1:0]         record_kind,
  input logic [2:0]         status,
  input logic signed [31:0] correlation_id,
  input logic [30:0]        topic_number,
  input logic [14:0]        name_length,
  input logic [30:0]        partition_total,
  input logic [30:0]        partition_position,
  input logic signed [31:0] partition_id,
  input logic signed [15:0] partition_error,
  input logic signed [63:0] partition_offset
);
  import prv0_pkg::*;

  // stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(record_kind) && $stable(status)
      && $stable(correlation_id) && $stable(topic_number) && $stable(name_length)
      && $stable(partition_total) && $stable(partition_position) && $stable(partition_id)
      && $stable(partition_error) && $stable(partition_offset))
    else $error("result changed while stalled");

  // input only backs up when a result is waiting
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> res_valid)
    else $error("input stalled with empty result side");

  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && record_kind == KIND_DONE |-> status == ST_OK && topic_number == '0
      && partition_offset == '0)
    else $error("done record malformed");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && record_kind == KIND_ERROR |-> status == ST_SHORT || status == ST_TRUNC
      || status == ST_BADTOPIC || status == ST_BADNAME || status == ST_BADPART)
    else $error("error record without error status");

  a_topic_rec: assert property (@(posedge clk) disable iff (rst)
    res_valid && record_kind == KIND_TOPIC |-> status == ST_OK && partition_position == '0
      && partition_id == '0 && partition_error == '0 && partition_offset == '0)
    else $error("topic record carries partition data");

endmodule

bind produce_response_v0_parser_unit prv0_check u_check (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for produce_response_v0_parser_unit: byte stream in, records out.
// Depends on prv0_pkg (hdl/prv0_pkg.sv) and the parser RTL; predicts every record itself.
module testbench;
  import prv0_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
    logic       eof;
  } xfer_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        sof;
    logic        eof;
    logic        typed;
    logic [1:0]  kind;
    logic [2:0]  stat;
    logic [31:0] corr;
  } dir_row_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SIZE, S_CORR, S_TCOUNT, S_NLEN, S_NAME, S_PCOUNT, S_PID, S_PERR, S_POFF, S_TRAIL
  } parse_phase_t;

  typedef enum {
    F_NONE, F_TRAIL, F_CUT, F_LONGER, F_SHORTER, F_NAME, F_PART, F_TOPIC, F_NOFINAL, F_TINY,
    F_GARBAGE
  } frame_fault_t;

  localparam int N_DIR = 26;
  localparam int N_BYTES = 1250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  logic [7:0] data_byte = 8'h00;
  logic start_flag = 1'b0;
  logic final_flag = 1'b0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [1:0] record_kind;
  logic [2:0] status;
  logic signed [31:0] correlation_id;
  logic [30:0] topic_number;
  logic [14:0] name_length;
  logic [30:0] partition_total;
  logic [30:0] partition_position;
  logic signed [31:0] partition_id;
  logic signed [15:0] partition_error;
  logic signed [63:0] partition_offset;

  produce_response_v0_parser_unit dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall),
    .data_byte(data_byte), .start_flag(start_flag), .final_flag(final_flag),
    .res_valid(res_valid), .res_stall(res_stall),
    .record_kind(record_kind), .status(status), .correlation_id(correlation_id),
    .topic_number(topic_number), .name_length(name_length),
    .partition_total(partition_total), .partition_position(partition_position),
    .partition_id(partition_id), .partition_error(partition_error),
    .partition_offset(partition_offset)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parser mirror
  parse_phase_t m_phase = S_IDLE;
  logic [3:0]  fld_cnt;
  logic [63:0] fld_acc;
  logic [32:0] msg_len;
  logic [32:0] pos;
  logic [31:0] corr_q;
  logic [30:0] topics_n;
  logic [30:0] topic_i;
  logic [14:0] name_left;
  logic [14:0] name_len_q;
  logic [30:0] parts_n;
  logic [30:0] part_i;
  logic [31:0] pid_q;
  logic [15:0] perr_q;
  bit          defer_v = 1'b0;
  res_t        defer_r = '0;

  res_t pending_records[$];
  logic [7:0] frame_bytes[$];
  int mismatches = 0;
  int bytes_fed = 0;
  int frames_fed = 0;
  int burst_left = 0;
  int kind_seen[4] = '{0, 0, 0, 0};

  function automatic void clear_frame();
    fld_cnt = '0; fld_acc = '0; msg_len = '0; pos = '0; corr_q = '0;
    topics_n = '0; topic_i = '0; name_left = '0; name_len_q = '0;
    parts_n = '0; part_i = '0; pid_q = '0; perr_q = '0;
  endfunction

  function automatic void step_topic();
    topic_i = topic_i + 31'd1;
    m_phase = (topic_i < topics_n) ? S_NLEN : S_TRAIL;
  endfunction

  function automatic bit parse_byte(input xfer_t x, output res_t r);
    bit have, have_rec, have_term;
    res_t rec, term;
    logic [2:0] err, tstat;
    logic [1:0] tkind;
    logic [32:0] idx;
    logic [31:0] v;
    int need;
    have = 1'b0; have_rec = 1'b0; have_term = 1'b0;
    r = '0; rec = '0; term = '0;
    err = ST_OK; tstat = ST_OK; tkind = KIND_ERROR;
    if (defer_v) begin
      r = defer_r;
      defer_v = 1'b0;
      have = 1'b1;
    end
    if (x.sof) begin
      clear_frame();
      m_phase = S_SIZE;
    end
    if (m_phase == S_IDLE) return have;
    idx = pos;
    if (pos != '1) pos = pos + 33'd1;
    if (m_phase >= S_NLEN && m_phase <= S_POFF && idx >= msg_len) begin
      err = ST_TRUNC;
    end else if (m_phase == S_NAME) begin
      name_left = name_left - 15'd1;
      if (name_left == 0) m_phase = S_PCOUNT;
    end else if (m_phase != S_TRAIL) begin
      need = (m_phase == S_NLEN || m_phase == S_PERR) ? 2 : (m_phase == S_POFF) ? 8 : 4;
      fld_acc = {fld_acc[55:0], x.data};
      fld_cnt = fld_cnt + 4'd1;
      if (fld_cnt >= 4'(need)) begin
        v = fld_acc[31:0];
        case (m_phase)
          S_SIZE: begin
            msg_len = 33'd4 + {1'b0, v};
            m_phase = S_CORR;
          end
          S_CORR: begin
            corr_q = v;
            m_phase = S_TCOUNT;
          end
          S_TCOUNT: begin
            if (v[31]) begin
              err = ST_BADTOPIC;
            end else begin
              topics_n = v[30:0];
              topic_i = '0;
              m_phase = (v != 0) ? S_NLEN : S_TRAIL;
            end
          end
          S_NLEN: begin
            if (v[15:0] == 16'hFFFF) v = '0;
            if (v[15]) begin
              err = ST_BADNAME;
            end else begin
              name_len_q = v[14:0];
              name_left = v[14:0];
              m_phase = (v[14:0] != 0) ? S_NAME : S_PCOUNT;
            end
          end
          S_PCOUNT: begin
            if (v[31]) begin
              err = ST_BADPART;
            end else begin
              parts_n = v[30:0];
              part_i = '0;
              rec.record_kind = KIND_TOPIC;
              rec.correlation_id = corr_q;
              rec.topic_number = topic_i;
              rec.name_length = name_len_q;
              rec.partition_total = v[30:0];
              have_rec = 1'b1;
              if (v != 0) m_phase = S_PID;
              else step_topic();
            end
          end
          S_PID: begin
            pid_q = v;
            m_phase = S_PERR;
          end
          S_PERR: begin
            perr_q = v[15:0];
            m_phase = S_POFF;
          end
          default: begin
            rec.record_kind = KIND_PART;
            rec.correlation_id = corr_q;
            rec.topic_number = topic_i;
            rec.name_length = name_len_q;
            rec.partition_total = parts_n;
            rec.partition_position = part_i;
            rec.partition_id = pid_q;
            rec.partition_error = perr_q;
            rec.partition_offset = fld_acc;
            have_rec = 1'b1;
            part_i = part_i + 31'd1;
            if (part_i < parts_n) m_phase = S_PID;
            else step_topic();
          end
        endcase
        fld_cnt = '0;
        fld_acc = '0;
      end
    end
    if (x.eof) begin
      have_term = 1'b1;
      if ({1'b0, idx} + 34'd1 < 34'(HEADER_BYTES)) tstat = ST_SHORT;
      else if ({1'b0, idx} + 34'd1 < {1'b0, msg_len}) tstat = ST_TRUNC;
      else if (err != ST_OK) tstat = err;
      else if (m_phase == S_TRAIL) begin
        tkind = KIND_DONE;
        tstat = ST_OK;
      end else tstat = ST_TRUNC;
      m_phase = S_IDLE;
    end else if (err != ST_OK) begin
      have_term = 1'b1;
      tstat = err;
      m_phase = S_IDLE;
    end
    if (have_rec && !have) begin
      r = rec;
      have = 1'b1;
    end
    if (have_term) begin
      term.record_kind = tkind;
      term.status = tstat;
      term.correlation_id = corr_q;
      if (!have) begin
        r = term;
        have = 1'b1;
      end else begin
        defer_v = 1'b1;
        defer_r = term;
      end
    end
    return have;
  endfunction

  function automatic void put_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) frame_bytes.push_back(v[8*i +: 8]);
  endfunction

  task automatic build_frame(input frame_fault_t fault);
    int n_topics, n_parts, nlen, bad, keep;
    logic [31:0] size_word;
    frame_bytes.delete();
    if (fault == F_TINY) begin
      put_be(64'($urandom), 1);
      return;
    end
    if (fault == F_GARBAGE) begin
      repeat ($urandom_range(1, 20)) put_be(64'($urandom), 1);
      return;
    end
    put_be(64'($urandom), 4);
    n_topics = (fault == F_NAME || fault == F_PART) ? $urandom_range(1, 3) : $urandom_range(0, 3);
    bad = (n_topics > 0) ? $urandom_range(0, n_topics - 1) : 0;
    if (fault == F_TOPIC) begin
      put_be(64'({1'b1, 31'($urandom)}), 4);
      repeat ($urandom_range(0, 6)) put_be(64'($urandom), 1);
    end else begin
      put_be(64'(n_topics), 4);
      for (int t = 0; t < n_topics; t++) begin
        if (fault == F_NAME && t == bad) begin
          put_be(64'($urandom_range(16'h8000, 16'hFFFE)), 2);
          repeat ($urandom_range(0, 4)) put_be(64'($urandom), 1);
          break;
        end
        nlen = $urandom_range(0, 5);
        if ($urandom_range(0, 5) == 0) begin
          put_be(64'(16'hFFFF), 2);
          nlen = 0;
        end else put_be(64'(nlen), 2);
        repeat (nlen) put_be(64'($urandom), 1);
        if (fault == F_PART && t == bad) begin
          put_be(64'({1'b1, 31'($urandom)}), 4);
          repeat ($urandom_range(0, 4)) put_be(64'($urandom), 1);
          break;
        end
        n_parts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 2);
        put_be(64'(n_parts), 4);
        repeat (n_parts) begin
          put_be(64'($urandom), 4);
          put_be(64'($urandom), 2);
          put_be({$urandom, $urandom}, 8);
        end
      end
    end
    size_word = frame_bytes.size();
    if (fault == F_LONGER) begin
      if ($urandom_range(0, 3) == 0) size_word = 32'hFFFF_FFFF;
      else size_word = size_word + $urandom_range(1, 20);
    end
    if (fault == F_SHORTER) size_word = size_word - $urandom_range(1, 8);
    if (fault == F_TRAIL) repeat ($urandom_range(1, 6)) put_be(64'($urandom), 1);
    for (int i = 0; i < 4; i++) frame_bytes.push_front(size_word[8*i +: 8]);
    if (fault == F_CUT) begin
      keep = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
  endtask

  task automatic send(input xfer_t x, input bit typed, input res_t want);
    res_t r;
    bit got;
    src_valid <= 1'b1;
    data_byte <= x.data;
    start_flag <= x.sof;
    final_flag <= x.eof;
    do @(posedge clk); while (src_stall);
    got = parse_byte(x, r);
    if (typed) pending_records.push_back(want);
    else if (got) pending_records.push_back(r);
  endtask

  // bursts with random gaps; drain holds the sender until every record is back
  task automatic pace(input bit drain);
    int gap;
    gap = 0;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 32);
      case ($urandom_range(0, 2))
        0: gap = 0;
        1: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(4, 10);
      endcase
    end
    if (drain) begin
      src_valid <= 1'b0;
      do @(posedge clk); while (pending_records.size() != 0);
    end else if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 200 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 3) == 0);
      2: res_stall <= ($urandom_range(0, 3) != 0);
      default: res_stall <= (stall_tick[2:0] < 3'd5);
    endcase
  end

  task automatic check_field(input string tag, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && res_valid && !res_stall) begin
      got = {record_kind, status, correlation_id, topic_number, name_length, partition_total,
             partition_position, partition_id, partition_error, partition_offset};
      if (pending_records.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected record, expected none, actual %0h", $time, got);
      end else begin
        want = pending_records.pop_front();
        kind_seen[want.record_kind]++;
        check_field("record_kind", 64'(want.record_kind), 64'(got.record_kind));
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("correlation_id", 64'(want.correlation_id), 64'(got.correlation_id));
        check_field("topic_number", 64'(want.topic_number), 64'(got.topic_number));
        check_field("name_length", 64'(want.name_length), 64'(got.name_length));
        check_field("partition_total", 64'(want.partition_total),
                    64'(got.partition_total));
        check_field("partition_position", 64'(want.partition_position),
                    64'(got.partition_position));
        check_field("partition_id", 64'(want.partition_id), 64'(got.partition_id));
        check_field("partition_error", 64'(want.partition_error),
                    64'(got.partition_error));
        check_field("partition_offset", want.partition_offset, got.partition_offset);
      end
    end
  end

  // idle byte, lone start+final, negative topic count, empty response closing exactly
  dir_row_t dir_tab [N_DIR] = '{
    '{8'hA5, 1'b0, 1'b1, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h3C, 1'b1, 1'b1, 1'b1, KIND_ERROR, ST_SHORT, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h80, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h80, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b1, KIND_ERROR, ST_BADTOPIC, 32'h8000_0000},
    '{8'h00, 1'b1, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h08, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h7F, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_TOPIC, ST_OK, 32'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, KIND_DONE, ST_OK, 32'h7FFF_FFFF}
  };

  initial begin
    xfer_t x;
    res_t want;
    frame_fault_t fault, prev_fault;
    int unsigned pick;
    int n_noise;
    m_phase = S_IDLE;
    clear_frame();
    prev_fault = F_NONE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      x = {dir_tab[i].data, dir_tab[i].sof, dir_tab[i].eof};
      want = '0;
      want.record_kind = dir_tab[i].kind;
      want.status = dir_tab[i].stat;
      want.correlation_id = dir_tab[i].corr;
      send(x, dir_tab[i].typed, want);
      pace(1'b0);
    end

    while (bytes_fed < N_BYTES) begin
      pick = $urandom_range(0, 99);
      if (prev_fault == F_NONE && pick < 20) fault = F_TINY;
      else if (pick < 45) fault = F_NONE;
      else if (pick < 52) fault = F_TRAIL;
      else if (pick < 58) fault = F_CUT;
      else if (pick < 63) fault = F_LONGER;
      else if (pick < 68) fault = F_SHORTER;
      else if (pick < 73) fault = F_NAME;
      else if (pick < 78) fault = F_PART;
      else if (pick < 82) fault = F_TOPIC;
      else if (pick < 88) fault = F_NOFINAL;
      else if (pick < 94) fault = F_TINY;
      else fault = F_GARBAGE;
      prev_fault = fault;
      build_frame(fault);
      for (int i = 0; i < frame_bytes.size(); i++) begin
        x.data = frame_bytes[i];
        x.sof = (i == 0);
        x.eof = (i == frame_bytes.size() - 1) && (fault != F_NOFINAL);
        send(x, 1'b0, '0);
        bytes_fed++;
        pace(frames_fed == 12 && i == frame_bytes.size() - 1);
      end
      frames_fed++;
      n_noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n_noise) begin
        x.data = 8'($urandom);
        x.sof = 1'b0;
        x.eof = 1'($urandom_range(0, 1));
        send(x, 1'b0, '0);
        pace(1'b0);
      end
    end

    // close on a clean response, then one idle byte to release a held terminal record
    build_frame(F_NONE);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      x.data = frame_bytes[i];
      x.sof = (i == 0);
      x.eof = (i == frame_bytes.size() - 1);
      send(x, 1'b0, '0);
      bytes_fed++;
      pace(1'b0);
    end
    frames_fed++;
    send('0, 1'b0, '0);
    src_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d directed and %0d random bytes over %0d responses", N_DIR, bytes_fed,
             frames_fed);
    $display("run: records seen - topic %0d, partition %0d, done %0d, error %0d",
             kind_seen[KIND_TOPIC], kind_seen[KIND_PART], kind_seen[KIND_DONE],
             kind_seen[KIND_ERROR]);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("run: timeout with %0d records outstanding", pending_records.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
hdl/prv0_pkg.sv
hdl/prv0_parse.sv
hdl/prv0_skid.sv
hdl/produce_response_v0_parser_unit.sv
hdl/prv0_check.sv
bench/testbench.sv
